/* rtl/core/stt_pkg.sv */
`default_nettype none

package stt_pkg;

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int IVAL_W  = 32;
  localparam int TAG_W   = 8;
  localparam int EVENT_W = 8;

  // Item kinds on the input channel.
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STOP,
    ST_TICK,
    ST_FLUSH
  } stt_state_t;

endpackage

`default_nettype wire

/* rtl/core/stt_if.sv */
`default_nettype none

interface stt_in_if import stt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [SLOT_W-1:0]  timer_slot;
  logic [IVAL_W-1:0]  interval_ticks;
  logic               is_periodic;
  logic [TAG_W-1:0]   queue_tag;
  logic [EVENT_W-1:0] event_code;

  modport source (
    output valid, kind, timer_slot, interval_ticks, is_periodic, queue_tag, event_code,
    input  ready
  );
  modport sink (
    input  valid, kind, timer_slot, interval_ticks, is_periodic, queue_tag, event_code,
    output ready
  );
endinterface

interface stt_out_if import stt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  expired_slot;
  logic [TAG_W-1:0]   out_queue;
  logic [EVENT_W-1:0] out_event;
  logic               last;

  modport source (
    output valid, expired_slot, out_queue, out_event, last,
    input  ready
  );
  modport sink (
    input  valid, expired_slot, out_queue, out_event, last,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/software_timer_set_unit.sv */
`default_nettype none

// Channel   Modport   Transfer when     Payload
// in_ch     sink      valid && ready    kind, timer_slot, interval_ticks, is_periodic,
//                                       queue_tag, event_code
// out_ch    source    valid && ready    expired_slot, out_queue, out_event, last
//
// A start writes its slot on accept, a stop reads it and checks its tag. A tick sweeps
// the slots through the single read port of the slot memory and the one decrementer,
// waiting while the result channel stalls. in_ch is ready only while the sequencer is
// idle. Reset clears the armed and periodic flags; no clearing pass is needed.
// A result waiting in the output register does not block the next transfer on in_ch.
module software_timer_set_unit import stt_pkg::*; #(
  parameter int NUM_TIMERS = 8,
  parameter int TICK_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  stt_in_if.sink    in_ch,
  stt_out_if.source out_ch
);

  localparam int AW     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int IW     = $clog2(NUM_TIMERS + 1);
  localparam int WORD_W = 2 * TICK_WIDTH + TAG_W + EVENT_W;

  stt_state_t state_r, state_nxt;

  logic [IW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         p_idx_r, p_idx_nxt;
  logic                  proc_v_r, proc_v_nxt;
  logic [TAG_W-1:0]      tag_r, tag_nxt;
  logic [NUM_TIMERS-1:0] armed_r, armed_nxt;
  logic [NUM_TIMERS-1:0] rpt_r, rpt_nxt;

  logic                  pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]     pend_slot_r, pend_slot_nxt;
  logic [TAG_W-1:0]      pend_queue_r, pend_queue_nxt;
  logic [EVENT_W-1:0]    pend_event_r, pend_event_nxt;

  logic                  out_v_r, out_v_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [TAG_W-1:0]      out_queue_r, out_queue_nxt;
  logic [EVENT_W-1:0]    out_event_r, out_event_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;

  logic [TICK_WIDTH-1:0] rd_reload, rd_ticks, dec;
  logic [TAG_W-1:0]      rd_queue;
  logic [EVENT_W-1:0]    rd_event;
  logic                  is_zero;

  logic                  in_accept, slot_ok, out_free;
  logic [6:0]            slot_ext, p_ext;
  logic [AW-1:0]         slot_addr;
  logic [63:0]           ival_ext;
  logic [TICK_WIDTH-1:0] start_ticks;
  logic                  proc_hit, expire, stall, sweep_done;

  stt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_TIMERS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign {rd_reload, rd_ticks, rd_queue, rd_event} = ram_rdata;

  // The one shared arithmetic unit: a decrement with a zero detect.
  assign dec     = rd_ticks - TICK_WIDTH'(1);
  assign is_zero = (dec == '0);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && (state_r == ST_IDLE);

  assign slot_ext    = {4'b0, in_ch.timer_slot};
  assign slot_ok     = (slot_ext < 7'(NUM_TIMERS));
  assign slot_addr   = slot_ext[AW-1:0];
  assign ival_ext    = {32'b0, in_ch.interval_ticks};
  assign start_ticks = (ival_ext[TICK_WIDTH-1:0] == '0) ? TICK_WIDTH'(1)
                                                        : ival_ext[TICK_WIDTH-1:0];
  assign p_ext       = 7'(p_idx_r);

  assign out_free   = !out_v_r || out_ch.ready;
  assign proc_hit   = (state_r == ST_TICK) && proc_v_r && armed_r[p_idx_r];
  assign expire     = proc_hit && is_zero;
  // A new expiry pushes the previous one out, so it needs a free output register.
  assign stall      = expire && pend_v_r && !out_free;
  assign sweep_done = !proc_v_r && (idx_r == IW'(NUM_TIMERS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_ch.kind == KIND_TICK) begin
            state_nxt = ST_TICK;
          end else if (in_ch.kind == KIND_STOP && slot_ok) begin
            state_nxt = ST_STOP;
          end
        end
      end
      ST_STOP: begin
        state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        if (sweep_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    idx_nxt        = idx_r;
    p_idx_nxt      = p_idx_r;
    proc_v_nxt     = proc_v_r;
    tag_nxt        = tag_r;
    armed_nxt      = armed_r;
    rpt_nxt        = rpt_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    pend_queue_nxt = pend_queue_r;
    pend_event_nxt = pend_event_r;
    out_v_nxt      = out_v_r && !out_ch.ready;
    out_slot_nxt   = out_slot_r;
    out_queue_nxt  = out_queue_r;
    out_event_nxt  = out_event_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = p_idx_r;
    ram_wdata      = {rd_reload, dec, rd_queue, rd_event};
    ram_re         = 1'b0;
    ram_raddr      = idx_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_ch.kind == KIND_TICK) begin
            idx_nxt    = '0;
            proc_v_nxt = 1'b0;
          end else if (in_ch.kind == KIND_START && slot_ok) begin
            ram_we               = 1'b1;
            ram_waddr            = slot_addr;
            ram_wdata            = {start_ticks, start_ticks, in_ch.queue_tag,
                                    in_ch.event_code};
            armed_nxt[slot_addr] = 1'b1;
            rpt_nxt[slot_addr]   = in_ch.is_periodic;
          end else if (in_ch.kind == KIND_STOP && slot_ok) begin
            ram_re    = 1'b1;
            ram_raddr = slot_addr;
            p_idx_nxt = slot_addr;
            tag_nxt   = in_ch.queue_tag;
          end
        end
      end
      ST_STOP: begin
        if (armed_r[p_idx_r] && rd_queue == tag_r) begin
          armed_nxt[p_idx_r] = 1'b0;
        end
      end
      ST_TICK: begin
        if (!stall) begin
          if (proc_hit) begin
            ram_we = 1'b1;
            if (is_zero) begin
              ram_wdata = {rd_reload, rd_reload, rd_queue, rd_event};
              if (!rpt_r[p_idx_r]) begin
                armed_nxt[p_idx_r] = 1'b0;
              end
              if (pend_v_r) begin
                out_v_nxt     = 1'b1;
                out_slot_nxt  = pend_slot_r;
                out_queue_nxt = pend_queue_r;
                out_event_nxt = pend_event_r;
                out_last_nxt  = 1'b0;
              end
              pend_v_nxt     = 1'b1;
              pend_slot_nxt  = p_ext[SLOT_W-1:0];
              pend_queue_nxt = rd_queue;
              pend_event_nxt = rd_event;
            end
          end
          if (idx_r < IW'(NUM_TIMERS)) begin
            ram_re     = 1'b1;
            ram_raddr  = idx_r[AW-1:0];
            p_idx_nxt  = idx_r[AW-1:0];
            proc_v_nxt = 1'b1;
            idx_nxt    = idx_r + IW'(1);
          end else begin
            proc_v_nxt = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        // The expiry still held is the final one of this tick.
        if (pend_v_r && out_free) begin
          out_v_nxt     = 1'b1;
          out_slot_nxt  = pend_slot_r;
          out_queue_nxt = pend_queue_r;
          out_event_nxt = pend_event_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      proc_v_r <= 1'b0;
      armed_r  <= '0;
      rpt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      proc_v_r <= proc_v_nxt;
      armed_r  <= armed_nxt;
      rpt_r    <= rpt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r      <= p_idx_nxt;
    tag_r        <= tag_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_queue_r <= pend_queue_nxt;
    pend_event_r <= pend_event_nxt;
    out_slot_r   <= out_slot_nxt;
    out_queue_r  <= out_queue_nxt;
    out_event_r  <= out_event_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.expired_slot = out_slot_r;
  assign out_ch.out_queue    = out_queue_r;
  assign out_ch.out_event    = out_event_r;
  assign out_ch.last         = out_last_r;

endmodule

`default_nettype wire

/* rtl/core/stt_ram.sv */
`default_nettype none

module stt_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                  wdata,
  input  wire logic                              re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import stt_pkg::*;

  localparam int NUM_SLOTS   = 8;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_OFF    = 300;

  // The fourth kind code is unused by the block and must be dropped quietly.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [IVAL_W-1:0]  interval;
    logic               periodic;
    logic [TAG_W-1:0]   tag;
    logic [EVENT_W-1:0] code;
  } timer_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic [EVENT_W-1:0] code;
    logic               last;
  } expiry_t;

  logic clk = 1'b0;
  logic rst_n;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  software_timer_set_unit #(
    .NUM_TIMERS (NUM_SLOTS),
    .TICK_WIDTH (IVAL_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the timer bank.
  logic              slot_armed    [NUM_SLOTS];
  logic              slot_periodic [NUM_SLOTS];
  logic              slot_written  [NUM_SLOTS];
  logic [IVAL_W-1:0] slot_reload   [NUM_SLOTS];
  logic [IVAL_W-1:0] slot_count    [NUM_SLOTS];
  logic [TAG_W-1:0]  slot_tag      [NUM_SLOTS];
  logic [EVENT_W-1:0] slot_code    [NUM_SLOTS];

  expiry_t expected_expiries[$];
  expiry_t seen_expiry;
  expiry_t want_expiry;

  int mismatches    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;

  function automatic void advance_timer_bank(input timer_cmd_t c);
    expiry_t fired[$];
    expiry_t e;
    logic [IVAL_W-1:0] ticks;
    if (c.kind == KIND_TICK) begin
      for (int n = 0; n < NUM_SLOTS; n++) begin
        if (!slot_armed[n]) continue;
        slot_count[n] = slot_count[n] - 1'b1;
        if (slot_count[n] != '0) continue;
        e.slot = SLOT_W'(n);
        e.tag  = slot_tag[n];
        e.code = slot_code[n];
        e.last = 1'b0;
        fired.push_back(e);
        if (slot_periodic[n]) begin
          slot_count[n] = slot_reload[n];
        end else begin
          slot_armed[n] = 1'b0;
        end
      end
      foreach (fired[i]) begin
        e = fired[i];
        e.last = (i == fired.size() - 1);
        expected_expiries.push_back(e);
      end
    end else if (c.kind == KIND_START) begin
      ticks = (c.interval == '0) ? IVAL_W'(1) : c.interval;
      slot_reload[c.slot]   = ticks;
      slot_count[c.slot]    = ticks;
      slot_periodic[c.slot] = c.periodic;
      slot_tag[c.slot]      = c.tag;
      slot_code[c.slot]     = c.code;
      slot_armed[c.slot]    = 1'b1;
      slot_written[c.slot]  = 1'b1;
    end else if (c.kind == KIND_STOP) begin
      if (slot_armed[c.slot] && slot_tag[c.slot] == c.tag) slot_armed[c.slot] = 1'b0;
    end
  endfunction

  function automatic timer_cmd_t make_cmd(input logic [KIND_W-1:0] kind,
                                          input int slot,
                                          input logic [IVAL_W-1:0] interval,
                                          input logic periodic,
                                          input logic [TAG_W-1:0] tag,
                                          input logic [EVENT_W-1:0] code);
    timer_cmd_t c;
    c.kind     = kind;
    c.slot     = SLOT_W'(slot);
    c.interval = interval;
    c.periodic = periodic;
    c.tag      = tag;
    c.code     = code;
    return c;
  endfunction

  // Mostly short intervals so that expiries come often; now and then a zero,
  // a full-range or the largest interval.
  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    int pick;
    int shape;
    pick       = $urandom_range(99);
    shape      = $urandom_range(99);
    c.kind     = KIND_START;
    c.slot     = SLOT_W'($urandom_range(NUM_SLOTS - 1));
    c.periodic = 1'($urandom_range(1));
    c.tag      = TAG_W'($urandom);
    c.code     = EVENT_W'($urandom);
    if (shape < 10) c.interval = '0;
    else if (shape < 20) c.interval = IVAL_W'($urandom);
    else if (shape < 23) c.interval = '1;
    else c.interval = IVAL_W'($urandom_range(1, 8));
    if (pick < 45) begin
      c.kind = KIND_TICK;
    end else if (pick >= 75 && pick < 95) begin
      // A stop only goes to a slot that has been started at least once.
      if (slot_written[c.slot]) begin
        c.kind = KIND_STOP;
        if (slot_armed[c.slot] && $urandom_range(3) != 0) c.tag = slot_tag[c.slot];
      end
    end else if (pick >= 95) begin
      c.kind = KIND_UNUSED;
    end
    return c;
  endfunction

  task automatic send_cmd(input timer_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= c.kind;
    in_ch.timer_slot     <= c.slot;
    in_ch.interval_ticks <= c.interval;
    in_ch.is_periodic    <= c.periodic;
    in_ch.queue_tag      <= c.tag;
    in_ch.event_code     <= c.code;
    do @(posedge clk); while (!in_ch.ready);
    advance_timer_bank(c);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_directed();
    send_cmd(make_cmd(KIND_START, 0, '0, 1'b0, 8'h00, 8'hFF));
    send_cmd(make_cmd(KIND_START, 7, '1, 1'b1, 8'hFF, 8'h00));
    send_cmd(make_cmd(KIND_TICK, 0, '0, 1'b0, 8'h00, 8'h00));
    // Quiet tick: slot 7 is far from expiry.
    send_cmd(make_cmd(KIND_TICK, 5, '1, 1'b1, 8'hFF, 8'hFF));
    send_cmd(make_cmd(KIND_STOP, 0, '0, 1'b0, 8'h00, 8'h00));
    send_cmd(make_cmd(KIND_START, 3, 32'd2, 1'b1, 8'h5A, 8'hA5));
    send_cmd(make_cmd(KIND_STOP, 7, '0, 1'b0, 8'h00, 8'h00));
    send_cmd(make_cmd(KIND_UNUSED, 3, '1, 1'b1, 8'h5A, 8'hFF));
    send_cmd(make_cmd(KIND_TICK, 0, '0, 1'b0, 8'h00, 8'h00));
    // Restart of an armed slot with new settings.
    send_cmd(make_cmd(KIND_START, 3, 32'd3, 1'b0, 8'h11, 8'h22));
    repeat (3) send_cmd(make_cmd(KIND_TICK, 0, '0, 1'b0, 8'h00, 8'h00));
    send_cmd(make_cmd(KIND_STOP, 7, '0, 1'b0, 8'hFF, 8'h00));
    for (int n = 0; n < NUM_SLOTS; n++) begin
      send_cmd(make_cmd(KIND_START, n, 32'd1, n[0] == 1'b0, TAG_W'(8'h30 + n),
                        EVENT_W'(8'hC0 + n)));
    end
    // Every slot fires on the first tick, only the periodic half on the second.
    send_cmd(make_cmd(KIND_TICK, 0, '0, 1'b0, 8'h00, 8'h00));
    send_cmd(make_cmd(KIND_TICK, 0, '0, 1'b0, 8'h00, 8'h00));
  endtask

  task automatic test_random(input int count);
    timer_cmd_t c;
    int done;
    done = 0;
    while (done < count) begin
      c = random_cmd();
      done++;
      send_cmd(c);
    end
  endtask

  // The receiver stalls for a long stretch while eight periodic slots fire on
  // every tick, so the output side backs up and the input stops taking items.
  task automatic test_backpressure();
    hold_cycles = HOLD_OFF;
    for (int n = 0; n < NUM_SLOTS; n++) begin
      send_cmd(make_cmd(KIND_START, n, 32'd1, 1'b1, TAG_W'($urandom), EVENT_W'($urandom)));
    end
    repeat (4) send_cmd(make_cmd(KIND_TICK, 0, '0, 1'b0, 8'h00, 8'h00));
    for (int n = 0; n < NUM_SLOTS; n++) begin
      send_cmd(make_cmd(KIND_STOP, n, '0, 1'b0, slot_tag[n], 8'h00));
    end
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_expiries.size() != 0) @(posedge clk);
    repeat (4 * NUM_SLOTS + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  endtask

  initial begin
    for (int n = 0; n < NUM_SLOTS; n++) begin
      slot_armed[n]    = 1'b0;
      slot_periodic[n] = 1'b0;
      slot_written[n]  = 1'b0;
    end
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.kind           = KIND_TICK;
    in_ch.timer_slot     = '0;
    in_ch.interval_ticks = '0;
    in_ch.is_periodic    = 1'b0;
    in_ch.queue_tag      = '0;
    in_ch.event_code     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(9, 67);
    test_directed();
    test_random(100);
    set_idling(67, 9);
    test_random(100);
    set_idling(0, 0);
    test_backpressure();
    test_random(100);
    finish_run();
  end

  // Result side: ready toggles at random, or stays low during a hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_expiry.slot = out_ch.expired_slot;
      seen_expiry.tag  = out_ch.out_queue;
      seen_expiry.code = out_ch.out_event;
      seen_expiry.last = out_ch.last;
      if (expected_expiries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected expiry: slot %0d queue %0h event %0h last %0b",
                   seen_expiry.slot, seen_expiry.tag, seen_expiry.code, seen_expiry.last);
      end else begin
        want_expiry = expected_expiries.pop_front();
        if (seen_expiry !== want_expiry) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expiry mismatch: expected slot %0d queue %0h event %0h last %0b,",
                     want_expiry.slot, want_expiry.tag, want_expiry.code, want_expiry.last,
                     " got slot %0d queue %0h event %0h last %0b",
                     seen_expiry.slot, seen_expiry.tag, seen_expiry.code, seen_expiry.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
